/* src/hfr_pkg.sv */
// ----------------------------------------------------------------------------
// hfr_pkg: shared types and constants for the HDLC frame receiver
// Holds the line codes, the CRC-16/CCITT constants, the status codes and the
// result record that passes from the deframer to the output register.
// ----------------------------------------------------------------------------
package hfr_pkg;

	localparam int MAX_FRAME_BYTES = 1024;
	localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
	localparam int LEN_W           = 10;

	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [7:0]  ESC_BYTE  = 8'h7D;
	localparam logic [7:0]  ESC_XOR   = 8'h20;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'h8408;

	localparam logic [1:0] ST_GOOD     = 2'd0;
	localparam logic [1:0] ST_SHORT    = 2'd1;
	localparam logic [1:0] ST_CRC      = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef struct packed {
		logic             is_frame_end;
		logic [7:0]       payload_byte;
		logic [1:0]       frame_status;
		logic [LEN_W-1:0] payload_length;
	} hfr_result_t;

endpackage

/* src/hfr_crc.sv */
// ----------------------------------------------------------------------------
// hfr_crc: byte-wide CRC-16/CCITT update
// Reflected polynomial 0x8408, one data byte folded into the running CRC.
// ----------------------------------------------------------------------------
module hfr_crc (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);
	import hfr_pkg::*;

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

/* src/hfr_deframer.sv */
// ----------------------------------------------------------------------------
// hfr_deframer: frame state, unescaping, CRC check and payload delay line
// Advances its state by one line byte when step is high and presents the
// result that byte causes, if any.
// ----------------------------------------------------------------------------
module hfr_deframer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte,
	output logic               res_valid,
	output hfr_pkg::hfr_result_t res
);
	import hfr_pkg::*;

	logic             in_frame_q;
	logic             escape_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0]      crc_q;
	logic [7:0]       delay_q [2];

	logic [7:0]       data_byte;
	logic [15:0]      crc_next;
	logic             is_flag;
	logic             is_esc;
	logic             has_room;
	logic [CNT_W-1:0] len_full;

	assign data_byte = escape_q ? (rx_byte ^ ESC_XOR) : rx_byte;
	assign is_flag   = (rx_byte == FLAG_BYTE);
	assign is_esc    = (rx_byte == ESC_BYTE);
	assign has_room  = (count_q < CNT_W'(MAX_FRAME_BYTES));
	assign len_full  = count_q - CNT_W'(2);

	hfr_crc u_crc (
		.crc_in  (crc_q),
		.data    (data_byte),
		.crc_out (crc_next)
	);

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (in_frame_q) begin
			if (is_flag) begin
				res_valid        = 1'b1;
				res.is_frame_end = 1'b1;
				if (count_q < CNT_W'(3)) begin
					res.frame_status = ST_SHORT;
				end else if (crc_q != 16'h0000) begin
					res.frame_status = ST_CRC;
				end else begin
					res.frame_status   = ST_GOOD;
					res.payload_length = LEN_W'(len_full);
				end
			end else if (!is_esc) begin
				if (has_room) begin
					res_valid        = (count_q >= CNT_W'(2));
					res.payload_byte = delay_q[0];
				end else begin
					res_valid        = 1'b1;
					res.is_frame_end = 1'b1;
					res.frame_status = ST_OVERFLOW;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			escape_q   <= 1'b0;
			count_q    <= '0;
			crc_q      <= CRC_INIT;
		end else if (step) begin
			if (!in_frame_q) begin
				if (is_flag) begin
					in_frame_q <= 1'b1;
					escape_q   <= 1'b0;
					count_q    <= '0;
					crc_q      <= CRC_INIT;
				end
			end else if (is_flag) begin
				in_frame_q <= 1'b0;
				escape_q   <= 1'b0;
				count_q    <= '0;
			end else if (is_esc) begin
				escape_q <= 1'b1;
			end else if (has_room) begin
				escape_q <= 1'b0;
				crc_q    <= crc_next;
				count_q  <= count_q + CNT_W'(1);
			end else begin
				in_frame_q <= 1'b0;
				escape_q   <= 1'b0;
				count_q    <= '0;
			end
		end
	end

	// shift unescaped data bytes; the two newest hold back the trailing CRC
	always_ff @(posedge clk) begin
		if (step && in_frame_q && !is_flag && !is_esc && has_room) begin
			delay_q[0] <= delay_q[1];
			delay_q[1] <= data_byte;
		end
	end

	a_hunt_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> count_q == '0)
		else $error("byte count nonzero while hunting");

	a_escape_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		escape_q |-> in_frame_q)
		else $error("escape pending outside a frame");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FRAME_BYTES))
		else $error("byte count beyond frame maximum");

endmodule

/* src/hdlc_frame_receiver.sv */
// ----------------------------------------------------------------------------
// hdlc_frame_receiver: HDLC byte-stuffed deframer with CRC-16/CCITT check
//
//   channel  dir  beat
//   s_axis   in   one raw line byte
//   m_axis   out  payload byte (tuser 0) or end-of-frame status (tuser 1)
//
// One line byte per cycle while the output is not stalled; a byte enters an input
// register and its result leaves from an output register.
// The deframer state advances in the cycle the byte leaves the input register.
// Reset clears the frame state to hunting; the delay line needs no reset.
// While m_tready is low the input register still takes one more byte, and
// bytes that cause no result keep flowing through.
// ----------------------------------------------------------------------------
module hdlc_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] payload_byte, [9:8] frame_status,
	                               // [19:10] payload_length, [23:20] zero
	output logic        m_tuser    // [0] is_frame_end
);
	import hfr_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        adv;
	logic        out_free;
	logic        res_valid;
	hfr_result_t res;
	hfr_result_t res_q;
	logic        m_tvalid_q;

	assign out_free = !m_tvalid_q || m_tready;
	assign adv      = valid_s1 && (!res_valid || out_free);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	hfr_deframer u_deframer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv && res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.is_frame_end;
	assign m_tdata  = {4'h0, res_q.payload_length, res_q.frame_status, res_q.payload_byte};

	a_end_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tdata[7:0] == 8'h00)
		else $error("end beat carries a payload byte");

	a_data_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> m_tdata[19:8] == 12'h000)
		else $error("payload beat carries status or length");

	a_bad_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser && m_tdata[9:8] != ST_GOOD) |-> m_tdata[19:10] == '0)
		else $error("failed frame reports a length");

endmodule
